### hdl/card_deck_stream_cipher_assert.svh
// ----------------------------------------------------------------------------
// Card deck stream cipher assertion macros
// Shorthand for the concurrent checks that sit at the end of the cipher module.
// ----------------------------------------------------------------------------
`ifndef CARD_DECK_STREAM_CIPHER_ASSERT_SVH
`define CARD_DECK_STREAM_CIPHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cdsc_pkg.sv
// ----------------------------------------------------------------------------
// Card deck stream cipher package
// Shared widths, codes, the shared adder operand bundle and the mod table.
// ----------------------------------------------------------------------------
`default_nettype none

package cdsc_pkg;

  localparam int unsigned DECK_SIZE_DEF = 40;
  localparam int unsigned CARD_W        = 6;
  localparam int unsigned CARD_SPAN     = 1 << CARD_W;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CFG_IDX_W     = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEC  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CUT_INDEX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_INDEX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_OFFSET = 2'd2;

  // Operands of the shared modular adder.
  typedef struct packed {
    logic [CARD_W-1:0] a;
    logic [CARD_W-1:0] b;
    logic              sub;
  } alu_op_t;

  typedef logic [CARD_SPAN-1:0][CARD_W-1:0] mod_tab_t;

  // Table of x mod n for every 6-bit x, built by counting.
  function automatic mod_tab_t mod_table(input int unsigned n);
    mod_tab_t    t;
    int unsigned c;
    c = 0;
    for (int i = 0; i < CARD_SPAN; i++) begin
      t[i] = CARD_W'(c);
      c = (c + 1 == n) ? 0 : c + 1;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/cdsc_in_if.sv
// ----------------------------------------------------------------------------
// Card deck stream cipher input channel
// Valid/ready channel carrying one load, encrypt or decrypt transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [cdsc_pkg::KIND_W-1:0]   kind;
  logic [cdsc_pkg::CARD_W-1:0]   card_value;
  logic [cdsc_pkg::CARD_W-1:0]   key_position;

  modport source (output valid, kind, card_value, key_position, input ready);
  modport sink   (input valid, kind, card_value, key_position, output ready);
endinterface

`default_nettype wire

### hdl/cdsc_out_if.sv
// ----------------------------------------------------------------------------
// Card deck stream cipher result channel
// Valid/ready channel carrying one cipher or plain card per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [cdsc_pkg::CARD_W-1:0] out_card;

  modport source (output valid, out_card, input ready);
  modport sink   (input valid, out_card, output ready);
endinterface

`default_nettype wire

### hdl/cdsc_cfg_if.sv
// ----------------------------------------------------------------------------
// Card deck stream cipher configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cdsc_pkg::CFG_IDX_W-1:0] index;
  logic [cdsc_pkg::CARD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/cdsc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/cdsc_modadd.sv
// ----------------------------------------------------------------------------
// Shared modular adder
// Reduces both operands mod the deck size, then adds or subtracts mod it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsc_modadd #(
  parameter int unsigned DECK_SIZE = cdsc_pkg::DECK_SIZE_DEF
) (
  input  wire cdsc_pkg::alu_op_t           op,
  output logic [cdsc_pkg::CARD_W-1:0]      res
);

  localparam int unsigned SUM_W = cdsc_pkg::CARD_W + 1;
  localparam cdsc_pkg::mod_tab_t MOD_TAB = cdsc_pkg::mod_table(DECK_SIZE);
  localparam logic [SUM_W-1:0] N_EXT = SUM_W'(DECK_SIZE);

  logic [cdsc_pkg::CARD_W-1:0] ra;
  logic [cdsc_pkg::CARD_W-1:0] rb;
  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            fixed;

  always_comb begin
    ra = MOD_TAB[op.a];
    rb = MOD_TAB[op.b];
    if (op.sub) begin
      sum = {1'b0, ra} + N_EXT - {1'b0, rb};
    end else begin
      sum = {1'b0, ra} + {1'b0, rb};
    end
    // Both forms stay below twice the deck size: one correction suffices.
    fixed = (sum >= N_EXT) ? sum - N_EXT : sum;
    res   = fixed[cdsc_pkg::CARD_W-1:0];
  end

endmodule

`default_nettype wire

### hdl/card_deck_stream_cipher.sv
// Flow: a load transaction is written in the cycle it is accepted; an
// encrypt or decrypt transaction shows its result after two deck scans and
// one shuffle pass through the single read port of the deck RAM. A new item
// is taken only once the last result has gone to the output register.
// Reset: a fill sweep writes the identity deck; no input is accepted meanwhile,
// configuration writes are taken at all times.
// ----------------------------------------------------------------------------
// Card deck stream cipher
// Keeps a shuffled card deck in a two-bank RAM and turns each plain card into
// a cipher card (or back) with a pad drawn from the deck, then reshuffles.
// ----------------------------------------------------------------------------
`default_nettype none

`include "card_deck_stream_cipher_assert.svh"

module card_deck_stream_cipher #(
  parameter int unsigned DECK_SIZE = cdsc_pkg::DECK_SIZE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cdsc_in_if.sink     in_ch,
  cdsc_out_if.source  out_ch,
  cdsc_cfg_if.sink    cfg_ch
);

  localparam int unsigned CW        = cdsc_pkg::CARD_W;
  localparam int unsigned IDX_W     = $clog2(DECK_SIZE);
  localparam int unsigned AW        = IDX_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** AW;
  localparam logic [IDX_W-1:0] CNT_LAST   = IDX_W'(DECK_SIZE - 1);
  localparam logic [IDX_W-1:0] HALF_BACK  = IDX_W'(DECK_SIZE / 2);
  localparam logic [IDX_W-1:0] HALF_FRONT = IDX_W'(DECK_SIZE / 2 - 1);
  localparam logic [CW:0]      N_EXT      = (CW + 1)'(DECK_SIZE);
  localparam cdsc_pkg::mod_tab_t MOD_TAB = cdsc_pkg::mod_table(DECK_SIZE);

  // The sequencer. Each deck search is a pipelined scan: a read is issued
  // every cycle and the compare of the previous read runs alongside it,
  // with a drain state after the last read. The shuffle works the same way,
  // reading the current bank in rotated order and writing each card into
  // the other bank in the cycle after its read.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WT,
    ST_SCAN,
    ST_SCAN_END,
    ST_PAD_RD,
    ST_PAD_WT,
    ST_CUT_RD,
    ST_CUT_WT,
    ST_ROT_SET,
    ST_SHUF,
    ST_SHUF_END,
    ST_EMIT
  } state_t;

  // Which search the scan belongs to: the mark card or the cut card.
  typedef enum logic {
    PH_MARK,
    PH_CUT
  } phase_t;

  // Control state.
  state_t            state_r,       state_nxt;
  logic [IDX_W-1:0]  cnt_r,         cnt_nxt;
  logic              pend_r,        pend_nxt;
  logic              bank_r,        bank_nxt;
  logic              out_valid_r,   out_valid_nxt;
  logic [CW-1:0]     out_card_r,    out_card_nxt;
  logic [CW-1:0]     cut_index_r,   cut_index_nxt;
  logic [CW-1:0]     mark_index_r,  mark_index_nxt;
  logic [CW-1:0]     mark_offset_r, mark_offset_nxt;

  // Working payload.
  phase_t                        phase_r,    phase_nxt;
  logic [IDX_W-1:0]              pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]              pos_r,      pos_nxt;
  logic [CW-1:0]                 target_r,   target_nxt;
  logic [IDX_W-1:0]              ptr_r,      ptr_nxt;
  logic [IDX_W-1:0]              back_r,     back_nxt;
  logic [IDX_W-1:0]              front_r,    front_nxt;
  logic [cdsc_pkg::KIND_W-1:0]   kind_r,     kind_nxt;
  logic [CW-1:0]                 card_r,     card_nxt;
  logic [CW-1:0]                 plain_r,    plain_nxt;
  logic [CW-1:0]                 result_r,   result_nxt;

  // Deck RAM ports and the shared adder.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CW-1:0]     ram_rdata;
  cdsc_pkg::alu_op_t alu_op;
  logic [CW-1:0]     alu_res;
  logic              in_acc;

  // The deck lives in two banks: bank_r selects the current deck, and the
  // shuffle writes the new order into the other bank, then flips bank_r.
  cdsc_ram #(
    .WIDTH (CW),
    .DEPTH (RAM_DEPTH)
  ) u_deck (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Every modular add or subtract of the item goes through this one unit.
  cdsc_modadd #(
    .DECK_SIZE (DECK_SIZE)
  ) u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_card = out_card_r;
  assign cfg_ch.ready    = 1'b1;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pend_nxt        = 1'b0;
    bank_nxt        = bank_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_card_nxt    = out_card_r;
    cut_index_nxt   = cut_index_r;
    mark_index_nxt  = mark_index_r;
    mark_offset_nxt = mark_offset_r;
    phase_nxt       = phase_r;
    pend_idx_nxt    = pend_idx_r;
    pos_nxt         = pos_r;
    target_nxt      = target_r;
    ptr_nxt         = ptr_r;
    back_nxt        = back_r;
    front_nxt       = front_r;
    kind_nxt        = kind_r;
    card_nxt        = card_r;
    plain_nxt       = plain_r;
    result_nxt      = result_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = {bank_r, cnt_r};
    alu_op          = '0;

    // Configuration writes; an index beyond the register list is dropped.
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cdsc_pkg::REG_CUT_INDEX:   cut_index_nxt   = cfg_ch.data;
        cdsc_pkg::REG_MARK_INDEX:  mark_index_nxt  = cfg_ch.data;
        cdsc_pkg::REG_MARK_OFFSET: mark_offset_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    // Compare lane of a scan: every position holding the target card is
    // ORed into pos_r, so no match leaves position zero.
    if (pend_r && (state_r inside {ST_SCAN, ST_SCAN_END})) begin
      if (MOD_TAB[ram_rdata] == target_r) begin
        pos_nxt = pos_r | pend_idx_r;
      end
    end

    // Write lane of the shuffle: the card read last cycle goes to its slot
    // in the other bank.
    if (pend_r && (state_r inside {ST_SHUF, ST_SHUF_END})) begin
      ram_we    = 1'b1;
      ram_waddr = {~bank_r, pend_idx_r};
      ram_wdata = ram_rdata;
    end

    case (state_r)
      ST_INIT: begin
        // Identity fill of bank zero after reset.
        ram_we    = 1'b1;
        ram_waddr = {1'b0, cnt_r};
        ram_wdata = CW'(cnt_r);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            cdsc_pkg::KIND_LOAD: begin
              // A key card goes straight into the current deck; a position
              // past the end of the deck is ignored.
              if ({1'b0, in_ch.key_position} < N_EXT) begin
                ram_we    = 1'b1;
                ram_waddr = {bank_r, in_ch.key_position[IDX_W-1:0]};
                ram_wdata = in_ch.card_value;
              end
            end
            cdsc_pkg::KIND_ENC, cdsc_pkg::KIND_DEC: begin
              kind_nxt  = in_ch.kind;
              card_nxt  = in_ch.card_value;
              state_nxt = ST_MARK_RD;
            end
            default: ;
          endcase
        end
      end
      ST_MARK_RD: begin
        alu_op    = '{a: mark_index_r, b: '0, sub: 1'b0};
        ram_raddr = {bank_r, alu_res[IDX_W-1:0]};
        state_nxt = ST_MARK_WT;
      end
      ST_MARK_WT: begin
        alu_op     = '{a: ram_rdata, b: mark_offset_r, sub: 1'b0};
        target_nxt = alu_res;
        cnt_nxt    = '0;
        pos_nxt    = '0;
        phase_nxt  = PH_MARK;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        ram_raddr    = {bank_r, cnt_r};
        pend_nxt     = 1'b1;
        pend_idx_nxt = cnt_r;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN_END: begin
        state_nxt = (phase_r == PH_MARK) ? ST_PAD_RD : ST_ROT_SET;
      end
      ST_PAD_RD: begin
        // The pad sits one position after the mark card.
        alu_op    = '{a: CW'(pos_r), b: CW'(1), sub: 1'b0};
        ram_raddr = {bank_r, alu_res[IDX_W-1:0]};
        state_nxt = ST_PAD_WT;
      end
      ST_PAD_WT: begin
        alu_op     = '{a: card_r, b: ram_rdata, sub: (kind_r == cdsc_pkg::KIND_DEC)};
        result_nxt = alu_res;
        plain_nxt  = (kind_r == cdsc_pkg::KIND_ENC) ? MOD_TAB[card_r] : alu_res;
        state_nxt  = ST_CUT_RD;
      end
      ST_CUT_RD: begin
        alu_op    = '{a: cut_index_r, b: '0, sub: 1'b0};
        ram_raddr = {bank_r, alu_res[IDX_W-1:0]};
        state_nxt = ST_CUT_WT;
      end
      ST_CUT_WT: begin
        alu_op     = '{a: plain_r, b: ram_rdata, sub: 1'b0};
        target_nxt = alu_res;
        cnt_nxt    = '0;
        pos_nxt    = '0;
        phase_nxt  = PH_CUT;
        state_nxt  = ST_SCAN;
      end
      ST_ROT_SET: begin
        // The ORed position may exceed the deck; reduce it for the rotation.
        alu_op    = '{a: CW'(pos_r), b: '0, sub: 1'b0};
        ptr_nxt   = alu_res[IDX_W-1:0];
        cnt_nxt   = '0;
        back_nxt  = HALF_BACK;
        front_nxt = HALF_FRONT;
        state_nxt = ST_SHUF;
      end
      ST_SHUF: begin
        // Even rotated cards fill the back half upward, odd ones the front
        // half downward.
        ram_raddr = {bank_r, ptr_r};
        pend_nxt  = 1'b1;
        if (cnt_r[0]) begin
          pend_idx_nxt = front_r;
          front_nxt    = front_r - 1'b1;
        end else begin
          pend_idx_nxt = back_r;
          back_nxt     = back_r + 1'b1;
        end
        ptr_nxt = (ptr_r == CNT_LAST) ? '0 : ptr_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SHUF_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SHUF_END: begin
        bank_nxt  = ~bank_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_card_nxt  = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      bank_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      out_card_r    <= '0;
      cut_index_r   <= '0;
      mark_index_r  <= '0;
      mark_offset_r <= '0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      pend_r        <= pend_nxt;
      bank_r        <= bank_nxt;
      out_valid_r   <= out_valid_nxt;
      out_card_r    <= out_card_nxt;
      cut_index_r   <= cut_index_nxt;
      mark_index_r  <= mark_index_nxt;
      mark_offset_r <= mark_offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    pend_idx_r <= pend_idx_nxt;
    pos_r      <= pos_nxt;
    target_r   <= target_nxt;
    ptr_r      <= ptr_nxt;
    back_r     <= back_nxt;
    front_r    <= front_nxt;
    kind_r     <= kind_nxt;
    card_r     <= card_nxt;
    plain_r    <= plain_nxt;
    result_r   <= result_nxt;
  end

  // A scan never leaves early.
  `CDSC_ASSERT_NEXT(a_scan_full, (state_r == ST_SCAN) && (cnt_r != CNT_LAST), state_r == ST_SCAN, "scan ended before the last deck position")
  // The finished shuffle always hands over to the other bank.
  `CDSC_ASSERT_NEXT(a_bank_flip, state_r == ST_SHUF_END, bank_r != $past(bank_r), "deck bank did not flip after the shuffle")
  // Pending reads come only from a scan or a shuffle step.
  `CDSC_ASSERT_SAME(a_pend_src, pend_r, ($past(state_r) == ST_SCAN) || ($past(state_r) == ST_SHUF), "pending read without a scan or shuffle step")
  // Every result card lies inside the deck.
  `CDSC_ASSERT_SAME(a_out_range, out_valid_r, {1'b0, out_card_r} < N_EXT, "result card outside the deck")

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card deck stream cipher testbench
// Drives load, encrypt and decrypt transactions into the cipher under random
// source gaps and sink stalls. A predictor keeps its own copy of the deck and
// registers, works out every cipher or plain card, and checks each result
// transaction in order.
// ----------------------------------------------------------------------------

module testbench;

  // Deck size of the block as instantiated, and cycles one cipher card takes:
  // two deck scans, one shuffle pass and the hand-off.
  localparam int          DECK        = cdsc_pkg::DECK_SIZE_DEF;
  localparam int          ITEM_CYCLES = 3 * DECK + 12;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_ITEMS = 700;

  // Codes the package leaves unnamed. The block must ignore both.
  localparam logic [cdsc_pkg::KIND_W-1:0]    KIND_SPARE = 2'd3;
  localparam logic [cdsc_pkg::CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  typedef struct packed {
    logic [cdsc_pkg::KIND_W-1:0] kind;
    logic [cdsc_pkg::CARD_W-1:0] card_value;
    logic [cdsc_pkg::CARD_W-1:0] key_position;
  } card_item_t;

  logic clk = 1'b0;
  logic rst_n;

  cdsc_in_if  in_if ();
  cdsc_out_if out_if ();
  cdsc_cfg_if cfg_if ();

  card_deck_stream_cipher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // Predictor state: the deck as the block should hold it, and the three
  // registers as last written.
  logic [cdsc_pkg::CARD_W-1:0] deck_model [DECK];
  logic [cdsc_pkg::CARD_W-1:0] cut_reg;
  logic [cdsc_pkg::CARD_W-1:0] mark_idx_reg;
  logic [cdsc_pkg::CARD_W-1:0] mark_off_reg;

  // Cards still owed by the block, oldest first.
  logic [cdsc_pkg::CARD_W-1:0] expected_cards [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Idle controls. The sender and the receiver each draw a random wait per
  // transaction while their flag is set. A nonzero hold asks the receiver to
  // keep ready low for that many cycles.
  bit          send_gaps_en   = 1'b1;
  bit          take_stalls_en = 1'b1;
  int unsigned take_hold_cycles = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int unsigned mod_deck(input int unsigned x);
    return x % DECK;
  endfunction

  // Position of a card in the deck. Cards are compared after reduction, so an
  // out-of-range key card matches its residue. Several matches OR their
  // positions together and no match gives position 0.
  function automatic int unsigned find_card(input int unsigned card);
    int unsigned pos;
    pos = 0;
    for (int i = 0; i < DECK; i++) begin
      if (mod_deck(deck_model[i]) == card) pos |= i;
    end
    return pos;
  endfunction

  // Cut the deck at a position, then deal the cut deck in pairs: the first
  // card of each pair grows the back half upward from the middle, the second
  // grows the front half downward from just below the middle.
  function automatic void deal_deck(input int unsigned start);
    logic [cdsc_pkg::CARD_W-1:0] rotated [DECK];
    int unsigned                 back_pos;
    int                          front_pos;
    back_pos  = DECK / 2;
    front_pos = DECK / 2 - 1;
    for (int i = 0; i < DECK; i++) rotated[i] = deck_model[mod_deck(i + start)];
    for (int i = 0; i < DECK; i += 2) begin
      if (back_pos < DECK) deck_model[back_pos] = rotated[i];
      if (front_pos >= 0 && i + 1 < DECK) deck_model[front_pos] = rotated[i + 1];
      back_pos++;
      front_pos--;
    end
  endfunction

  // Applies one accepted transaction to the deck. Returns 1 and the card the
  // block must produce for encrypt and decrypt, 0 for everything else.
  function automatic bit predict_cipher(input card_item_t it,
                                        output logic [cdsc_pkg::CARD_W-1:0] card_out);
    int unsigned mark_sum;
    int unsigned pad;
    int unsigned plain;
    int unsigned result;
    int unsigned cut_sum;
    card_out = '0;
    case (it.kind)
      cdsc_pkg::KIND_LOAD: begin
        // A key card is stored as given; a position off the deck is dropped.
        if (it.key_position < DECK) deck_model[it.key_position] = it.card_value;
        return 1'b0;
      end
      cdsc_pkg::KIND_ENC, cdsc_pkg::KIND_DEC: begin
        mark_sum = mod_deck(mod_deck(deck_model[mod_deck(mark_idx_reg)]) +
                            mod_deck(mark_off_reg));
        pad = mod_deck(deck_model[mod_deck(find_card(mark_sum) + 1)]);
        if (it.kind == cdsc_pkg::KIND_ENC) begin
          plain  = mod_deck(it.card_value);
          result = mod_deck(plain + pad);
        end else begin
          plain  = mod_deck(mod_deck(it.card_value) + DECK - pad);
          result = plain;
        end
        // The reshuffle always keys off the plain card, in both directions.
        cut_sum = mod_deck(plain + mod_deck(deck_model[mod_deck(cut_reg)]));
        deal_deck(mod_deck(find_card(cut_sum)));
        card_out = cdsc_pkg::CARD_W'(result);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Every result transaction is compared with the oldest card still owed.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_cards.size() == 0) begin
        report_mismatch($sformatf("card %0d arrived with none owed", out_if.out_card));
      end else if (out_if.out_card !== expected_cards[0]) begin
        report_mismatch($sformatf("out_card %0d, expected %0d",
                                  out_if.out_card, expected_cards[0]));
        void'(expected_cards.pop_front());
      end else begin
        void'(expected_cards.pop_front());
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // A run that hangs on a handshake never reaches the final verdict.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result receiver. It owns out_if.ready. Each transaction it may stall for
  // a drawn number of cycles; a hold request turns into one long stretch of
  // ready low so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : result_taker
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (take_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (take_hold_cycles) @(posedge clk);
        take_hold_cycles = 0;
      end
      stall = take_stalls_en ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      // Leave early when a hold is requested so it starts right away.
      do @(posedge clk); while (out_if.valid !== 1'b1 && take_hold_cycles == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one transaction and waits until it is taken. Valid stays high on
  // return so a back-to-back transaction needs no second assignment in the
  // same step; quiesce_block drops it when the stream pauses.
  task automatic send_item(input card_item_t item);
    int unsigned                 gap;
    logic [cdsc_pkg::CARD_W-1:0] card_out;
    gap = send_gaps_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= item.kind;
    in_if.card_value   <= item.card_value;
    in_if.key_position <= item.key_position;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (predict_cipher(item, card_out)) expected_cards.push_back(card_out);
  endtask

  function automatic card_item_t make_item(input logic [cdsc_pkg::KIND_W-1:0] kind,
                                           input int unsigned card,
                                           input int unsigned pos);
    card_item_t item;
    item.kind         = kind;
    item.card_value   = cdsc_pkg::CARD_W'(card);
    item.key_position = cdsc_pkg::CARD_W'(pos);
    return item;
  endfunction

  // Stops offering, waits for every owed card, then lets a full card time
  // pass so a trailing load has surely landed before registers change.
  task automatic quiesce_block();
    in_if.valid <= 1'b0;
    while (expected_cards.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back, and the unused index too when
  // asked. Only call this while the block is quiet.
  task automatic load_registers(input logic [cdsc_pkg::CARD_W-1:0] cut_val,
                                input logic [cdsc_pkg::CARD_W-1:0] mark_val,
                                input logic [cdsc_pkg::CARD_W-1:0] offset_val,
                                input bit poke_spare);
    logic [cdsc_pkg::CFG_IDX_W-1:0] idx [4];
    logic [cdsc_pkg::CARD_W-1:0]    val [4];
    int                             n;
    idx[0] = cdsc_pkg::REG_CUT_INDEX;   val[0] = cut_val;
    idx[1] = cdsc_pkg::REG_MARK_INDEX;  val[1] = mark_val;
    idx[2] = cdsc_pkg::REG_MARK_OFFSET; val[2] = offset_val;
    idx[3] = REG_SPARE;                 val[3] = '1;
    n = poke_spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
      case (idx[k])
        cdsc_pkg::REG_CUT_INDEX:   cut_reg      = val[k];
        cdsc_pkg::REG_MARK_INDEX:  mark_idx_reg = val[k];
        cdsc_pkg::REG_MARK_OFFSET: mark_off_reg = val[k];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Card values mostly in the deck range, now and then past it.
  function automatic int unsigned random_card();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(DECK, 63)
                                       : $urandom_range(0, DECK - 1);
  endfunction

  // Register values favor the ends of the range and the wrap region.
  function automatic logic [cdsc_pkg::CARD_W-1:0] random_register();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return cdsc_pkg::CARD_W'(DECK - 1);
      2:       return cdsc_pkg::CARD_W'($urandom_range(DECK, 63));
      default: return cdsc_pkg::CARD_W'($urandom_range(0, DECK - 1));
    endcase
  endfunction

  // Message traffic: mostly cipher cards, with stray key loads (some off the
  // deck) and the spare kind mixed in as noise.
  function automatic card_item_t random_message_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return make_item(cdsc_pkg::KIND_LOAD, random_card(), $urandom_range(0, 47));
    if (r < 12) return make_item(KIND_SPARE, $urandom_range(0, 63), $urandom_range(0, 63));
    if (r < 56) return make_item(cdsc_pkg::KIND_ENC, random_card(), $urandom_range(0, 63));
    return make_item(cdsc_pkg::KIND_DEC, random_card(), $urandom_range(0, 63));
  endfunction

  // Loads a fresh key: a shuffled permutation written to every position.
  task automatic load_key_deck();
    logic [cdsc_pkg::CARD_W-1:0] order [DECK];
    logic [cdsc_pkg::CARD_W-1:0] swap_card;
    int unsigned                 j;
    for (int i = 0; i < DECK; i++) order[i] = cdsc_pkg::CARD_W'(i);
    for (int i = DECK - 1; i > 0; i--) begin
      j            = $urandom_range(0, i);
      swap_card    = order[i];
      order[i]     = order[j];
      order[j]     = swap_card;
    end
    for (int i = 0; i < DECK; i++) send_item(make_item(cdsc_pkg::KIND_LOAD, order[i], i));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Ends of the card range starting from the identity deck, oversize cards, the spare
  // kind, key loads off the deck, and an out-of-range key card that leaves
  // the deck with a duplicate residue and a missing card so that searches hit
  // both the OR of several positions and the no-match case.
  task automatic test_directed_cards();
    send_item(make_item(cdsc_pkg::KIND_ENC, 0, 0));
    send_item(make_item(cdsc_pkg::KIND_ENC, DECK - 1, 63));
    send_item(make_item(cdsc_pkg::KIND_DEC, 0, 0));
    send_item(make_item(cdsc_pkg::KIND_DEC, DECK - 1, 63));
    send_item(make_item(cdsc_pkg::KIND_ENC, 63, 0));
    send_item(make_item(cdsc_pkg::KIND_DEC, DECK, 0));
    send_item(make_item(KIND_SPARE, 63, 63));
    send_item(make_item(cdsc_pkg::KIND_LOAD, 63, 0));
    send_item(make_item(cdsc_pkg::KIND_LOAD, DECK - 1, DECK - 1));
    send_item(make_item(cdsc_pkg::KIND_LOAD, 5, 63));
    send_item(make_item(cdsc_pkg::KIND_LOAD, 0, DECK));
    send_item(make_item(cdsc_pkg::KIND_ENC, 23, 0));
    send_item(make_item(cdsc_pkg::KIND_DEC, 17, 0));
    send_item(make_item(cdsc_pkg::KIND_ENC, 5, 0));
  endtask

  // Registers at the top of the range, at all ones (wrapping mod the deck
  // size), and mixed. The unused index is written once and must change
  // nothing.
  task automatic test_register_extremes();
    logic [cdsc_pkg::CARD_W-1:0] settings [3][3];
    settings[0] = '{cdsc_pkg::CARD_W'(DECK - 1), cdsc_pkg::CARD_W'(DECK - 1),
                    cdsc_pkg::CARD_W'(DECK - 1)};
    settings[1] = '{'1, '1, '1};
    settings[2] = '{cdsc_pkg::CARD_W'(DECK), '0, cdsc_pkg::CARD_W'(DECK + 22)};
    for (int s = 0; s < 3; s++) begin
      quiesce_block();
      load_registers(settings[s][0], settings[s][1], settings[s][2], s == 1);
      send_item(make_item(cdsc_pkg::KIND_ENC, random_card(), 0));
      send_item(make_item(cdsc_pkg::KIND_DEC, random_card(), 0));
      send_item(make_item(cdsc_pkg::KIND_ENC, DECK - 1, 0));
      send_item(make_item(cdsc_pkg::KIND_DEC, 0, 0));
    end
  endtask

  // The receiver holds ready low for several card times while the sender
  // keeps offering, so the finished card waits and the input stalls behind it.
  task automatic test_output_backpressure();
    quiesce_block();
    take_hold_cycles = 4 * ITEM_CYCLES;
    for (int i = 0; i < 6; i++) begin
      send_item(make_item(($urandom_range(0, 1) != 0) ? cdsc_pkg::KIND_ENC
                                                      : cdsc_pkg::KIND_DEC,
                          random_card(), 0));
    end
    quiesce_block();
  endtask

  // Phases of message traffic. Each phase starts from a quiet block with new
  // register values and, half the time, a freshly keyed deck. Idle patterns
  // rotate so that some phases run with no gaps or stalls at all.
  task automatic test_random_messages();
    int unsigned fed_items;
    int unsigned phase;
    int unsigned msg_len;
    card_item_t  item;
    fed_items = 0;
    phase     = 0;
    while (fed_items < RANDOM_ITEMS) begin
      quiesce_block();
      load_registers(random_register(), random_register(), random_register(), 1'b0);
      send_gaps_en   = (phase % 3) != 0;
      take_stalls_en = (phase % 4) != 1;
      if ($urandom_range(0, 1) != 0) begin
        load_key_deck();
        fed_items += DECK;
      end
      msg_len = $urandom_range(15, 35);
      for (int i = 0; i < msg_len; i++) begin
        item = random_message_item();
        send_item(item);
        fed_items++;
      end
      phase++;
    end
    send_gaps_en   = 1'b1;
    take_stalls_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    in_if.valid        <= 1'b0;
    in_if.kind         <= cdsc_pkg::KIND_LOAD;
    in_if.card_value   <= '0;
    in_if.key_position <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= cdsc_pkg::REG_CUT_INDEX;
    cfg_if.data        <= '0;
    rst_n              <= 1'b0;

    // Reset state: identity deck, all registers zero.
    for (int i = 0; i < DECK; i++) deck_model[i] = cdsc_pkg::CARD_W'(i);
    cut_reg      = '0;
    mark_idx_reg = '0;
    mark_off_reg = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The block fills its deck with the identity order after reset; the first
    // transaction simply waits for ready.
    test_directed_cards();
    test_register_extremes();
    test_output_backpressure();
    test_random_messages();

    quiesce_block();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
